### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int CHAR_W   = 8;
   localparam int NIBBLE_W = 4;
   localparam int ATTR_W   = 8;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;

   // op codes
   localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_COLOR = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH      = 3'd2;
   localparam logic [OP_W-1:0] OP_POP       = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_CELL = 3'd5;

   // control characters
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;

   localparam int TAB_SPACES = 4;
   localparam int TAB_W      = $clog2(TAB_SPACES);

   typedef enum logic [3:0] {
      CMD_PRINT,
      CMD_CR,
      CMD_LF,
      CMD_BS,
      CMD_TAB,
      CMD_SET,
      CMD_PUSH,
      CMD_POP,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [CHAR_W-1:0]   char_code;
      logic                update_cursor;
      logic [NIBBLE_W-1:0] fg;
      logic [NIBBLE_W-1:0] bg;
      logic [CURSOR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] shown_cursor;
      logic [CELL_W-1:0]   cell_value;
      logic [ATTR_W-1:0]   color_now;
      logic                error;
   } rsp_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   ch;
      logic                upd;
      logic [ATTR_W-1:0]   attr;
      logic [CURSOR_W-1:0] idx;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire tcw_pkg::req_type req_data,
   input  wire logic            hold,
   output logic                 cmd_valid,
   output tcw_pkg::cmd_type     cmd,
   input  wire logic            cmd_pop
);

   tcw_pkg::cmd_type q_ff [2];
   tcw_pkg::cmd_type cmd_new;
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      cmd_new.ch   = req_data.char_code;
      cmd_new.upd  = req_data.update_cursor;
      cmd_new.attr = {req_data.bg, req_data.fg};
      cmd_new.idx  = req_data.cell_index;
      case (req_data.op)
         tcw_pkg::OP_PUT_CHAR: begin
            case (req_data.char_code)
               tcw_pkg::CHAR_CR: cmd_new.kind = tcw_pkg::CMD_CR;
               tcw_pkg::CHAR_LF: cmd_new.kind = tcw_pkg::CMD_LF;
               tcw_pkg::CHAR_BS: cmd_new.kind = tcw_pkg::CMD_BS;
               tcw_pkg::CHAR_TAB: begin
                  cmd_new.kind = tcw_pkg::CMD_TAB;
                  cmd_new.ch   = tcw_pkg::CHAR_BLANK;
               end
               default: cmd_new.kind = tcw_pkg::CMD_PRINT;
            endcase
         end
         tcw_pkg::OP_SET_COLOR: cmd_new.kind = tcw_pkg::CMD_SET;
         tcw_pkg::OP_PUSH:      cmd_new.kind = tcw_pkg::CMD_PUSH;
         tcw_pkg::OP_POP:       cmd_new.kind = tcw_pkg::CMD_POP;
         tcw_pkg::OP_CLEAR:     cmd_new.kind = tcw_pkg::CMD_CLEAR;
         tcw_pkg::OP_READ_CELL: cmd_new.kind = tcw_pkg::CMD_READ;
         default:               cmd_new.kind = tcw_pkg::CMD_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2) || hold;
   assign do_push   = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign do_pop    = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/core/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Carries out queued console commands on the screen memory and color stack.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine #(
   parameter int SCREEN_WIDTH      = 80,
   parameter int SCREEN_HEIGHT     = 25,
   parameter int COLOR_STACK_DEPTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire tcw_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   output logic                  init_busy,
   output logic                  rsp_valid,
   output tcw_pkg::rsp_type      rsp,
   input  wire logic             rsp_pop
);

   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(SCREEN_WIDTH);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int CNT_W  = $clog2(COLOR_STACK_DEPTH + 1);
   localparam int SP_W   = (COLOR_STACK_DEPTH > 1) ? $clog2(COLOR_STACK_DEPTH) : 1;
   localparam int POS_W  = (ADDR_W > tcw_pkg::CURSOR_W) ? ADDR_W : tcw_pkg::CURSOR_W;

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - SCREEN_WIDTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);
   localparam logic [ADDR_W-1:0] SRC_NEXT  = ADDR_W'(SCREEN_WIDTH + 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [CNT_W-1:0]  STACK_MAX = CNT_W'(COLOR_STACK_DEPTH);
   localparam logic [POS_W-1:0]  CELLS_W   = POS_W'(CELLS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_STEP_DONE,
      ST_SCR_PRIME,
      ST_SCR_COPY,
      ST_FILL,
      ST_POP_WAIT,
      ST_READ_WAIT,
      ST_RESULT
   } state_type;

   state_type                     state_ff, state_in;
   state_type                     fill_next_ff, fill_next_in;
   tcw_pkg::cmd_type              cmd_ff, cmd_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [ADDR_W-1:0]             row_base_ff, row_base_in;
   logic [ADDR_W-1:0]             shown_ff, shown_in;
   logic [tcw_pkg::ATTR_W-1:0]    color_ff, color_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [tcw_pkg::TAB_W-1:0]     tab_left_ff, tab_left_in;
   logic [ADDR_W-1:0]             scan_ff, scan_in;
   logic [tcw_pkg::CELL_W-1:0]    cell_ff, cell_in;
   logic                          err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          scr_we;
   logic [ADDR_W-1:0]             scr_waddr;
   logic [tcw_pkg::CELL_W-1:0]    scr_wdata;
   logic [ADDR_W-1:0]             scr_raddr;
   logic [tcw_pkg::CELL_W-1:0]    scr_rdata;
   logic                          stk_we;
   logic [SP_W-1:0]               stk_raddr;
   logic [tcw_pkg::ATTR_W-1:0]    stk_rdata;

   logic [ADDR_W-1:0]             pos;
   logic [tcw_pkg::CELL_W-1:0]    blank;
   logic [POS_W-1:0]              idx_wide;
   logic [POS_W-1:0]              shown_wide;
   logic [CNT_W-1:0]              count_dec;
   logic                          rsp_take;

   assign pos        = row_base_ff + ADDR_W'(col_ff);
   assign blank      = {color_ff, tcw_pkg::CHAR_BLANK};
   assign idx_wide   = POS_W'(cmd.idx);
   assign shown_wide = POS_W'(shown_ff);
   assign count_dec  = count_ff - CNT_W'(1);
   assign rsp_take   = rsp_valid_ff && rsp_pop;
   assign init_busy  = (state_ff == ST_FILL) && (fill_next_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (scr_wdata),
      .rd_addr (scr_raddr),
      .rd_data (scr_rdata)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::ATTR_W),
      .DEPTH (COLOR_STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (count_ff[SP_W-1:0]),
      .wr_data (color_ff),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      fill_next_in = fill_next_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_base_in  = row_base_ff;
      shown_in     = shown_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      tab_left_in  = tab_left_ff;
      scan_in      = scan_ff;
      cell_in      = cell_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      scr_we       = 1'b0;
      scr_waddr    = scan_ff;
      scr_wdata    = blank;
      scr_raddr    = scan_ff;
      stk_we       = 1'b0;
      stk_raddr    = count_dec[SP_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               err_in      = 1'b0;
               cell_in     = '0;
               tab_left_in = '0;
               case (cmd.kind)
                  tcw_pkg::CMD_PRINT: state_in = ST_WRITE;
                  tcw_pkg::CMD_TAB: begin
                     tab_left_in = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES - 1);
                     state_in    = ST_WRITE;
                  end
                  tcw_pkg::CMD_CR: begin
                     col_in   = '0;
                     state_in = ST_STEP_DONE;
                  end
                  tcw_pkg::CMD_LF: begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        scan_in  = '0;
                        state_in = ST_SCR_PRIME;
                     end else begin
                        row_in      = row_ff + ROW_W'(1);
                        row_base_in = row_base_ff + ROW_STEP;
                        state_in    = ST_STEP_DONE;
                     end
                  end
                  tcw_pkg::CMD_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end else if (row_ff != '0) begin
                        col_in      = LAST_COL;
                        row_in      = row_ff - ROW_W'(1);
                        row_base_in = row_base_ff - ROW_STEP;
                     end
                     state_in = ST_STEP_DONE;
                  end
                  tcw_pkg::CMD_SET: begin
                     color_in = cmd.attr;
                     state_in = ST_RESULT;
                  end
                  tcw_pkg::CMD_PUSH: begin
                     if (count_ff == STACK_MAX) begin
                        err_in = 1'b1;
                     end else begin
                        stk_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        color_in = cmd.attr;
                     end
                     state_in = ST_RESULT;
                  end
                  tcw_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        err_in   = 1'b1;
                        state_in = ST_RESULT;
                     end else begin
                        count_in = count_dec;
                        state_in = ST_POP_WAIT;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     col_in       = '0;
                     row_in       = '0;
                     row_base_in  = '0;
                     shown_in     = '0;
                     scan_in      = '0;
                     fill_next_in = ST_RESULT;
                     state_in     = ST_FILL;
                  end
                  tcw_pkg::CMD_READ: begin
                     if (idx_wide < CELLS_W) begin
                        scr_raddr = idx_wide[ADDR_W-1:0];
                        state_in  = ST_READ_WAIT;
                     end else begin
                        state_in = ST_RESULT;
                     end
                  end
                  default: state_in = ST_RESULT;
               endcase
            end
         end

         ST_WRITE: begin
            scr_we    = 1'b1;
            scr_waddr = pos;
            scr_wdata = {color_ff, cmd_ff.ch};
            if (col_ff == LAST_COL) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  scan_in  = '0;
                  state_in = ST_SCR_PRIME;
               end else begin
                  row_in      = row_ff + ROW_W'(1);
                  row_base_in = row_base_ff + ROW_STEP;
                  state_in    = ST_STEP_DONE;
               end
            end else begin
               col_in   = col_ff + COL_W'(1);
               state_in = ST_STEP_DONE;
            end
         end

         ST_SCR_PRIME: begin
            scr_raddr = ROW_STEP;
            state_in  = ST_SCR_COPY;
         end

         ST_SCR_COPY: begin
            scr_we    = 1'b1;
            scr_waddr = scan_ff;
            scr_wdata = scr_rdata;
            scr_raddr = scan_ff + SRC_NEXT;
            scan_in   = scan_ff + ADDR_W'(1);
            if (scan_ff == COPY_LAST) begin
               fill_next_in = ST_STEP_DONE;
               state_in     = ST_FILL;
            end
         end

         ST_FILL: begin
            scr_we    = 1'b1;
            scr_waddr = scan_ff;
            scr_wdata = blank;
            if (scan_ff == LAST_CELL) begin
               state_in = fill_next_ff;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
            end
         end

         ST_STEP_DONE: begin
            if (tab_left_ff != '0) begin
               tab_left_in = tab_left_ff - tcw_pkg::TAB_W'(1);
               state_in    = ST_WRITE;
            end else begin
               if (cmd_ff.upd || (cmd_ff.kind == tcw_pkg::CMD_TAB)) begin
                  shown_in = pos;
               end
               state_in = ST_RESULT;
            end
         end

         ST_POP_WAIT: begin
            color_in = stk_rdata;
            state_in = ST_RESULT;
         end

         ST_READ_WAIT: begin
            cell_in  = scr_rdata;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in        = 1'b1;
               rsp_in.shown_cursor = shown_wide[tcw_pkg::CURSOR_W-1:0];
               rsp_in.cell_value   = cell_ff;
               rsp_in.color_now    = color_ff;
               rsp_in.error        = err_ff;
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cell_ff <= cell_in;
      err_ff  <= err_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_next_ff <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         row_base_ff  <= '0;
         shown_ff     <= '0;
         color_ff     <= tcw_pkg::RESET_COLOR;
         count_ff     <= '0;
         tab_left_ff  <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_next_ff <= fill_next_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_base_ff  <= row_base_in;
         shown_ff     <= shown_in;
         color_ff     <= color_in;
         count_ff     <= count_in;
         tab_left_ff  <= tab_left_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell console: screen memory, cursor, color and color stack.
// ----------------------------------------------------------------------------
// After reset the screen memory is swept to blank cells, one cell a cycle,
// over all SCREEN_WIDTH*SCREEN_HEIGHT cells (2000 by default); full stays
// high until the sweep is over. Set, push and the unused op codes go
// straight to the result; pop and read wait on a memory read; CR, LF and BS
// move the cursor; a printable character is written to the screen memory.
// The sequencer takes the next request once it is back in idle. TAB writes
// four cells. Every cell write goes through the single write port of the
// screen memory, so a clear writes the cells one by one and a scroll (a
// character or LF past the last line) copies each row up one and blanks the
// last row. A two-entry command queue sits before the sequencer and a result
// register after it, so requests keep coming in while a result waits; the
// sequencer stalls while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
   parameter int SCREEN_WIDTH      = 80,
   parameter int SCREEN_HEIGHT     = 25,
   parameter int COLOR_STACK_DEPTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire tcw_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output tcw_pkg::rsp_type      rsp_data
);

   tcw_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;
   logic             init_busy;
   logic             rsp_valid;

   tcw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .hold      (init_busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tcw_engine #(
      .SCREEN_WIDTH      (SCREEN_WIDTH),
      .SCREEN_HEIGHT     (SCREEN_HEIGHT),
      .COLOR_STACK_DEPTH (COLOR_STACK_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .rsp_pop   (pop)
   );

   assign empty = !rsp_valid;

endmodule

`default_nettype wire
